// ----- src/internet_checksum_engine_macros.svh -----
// Assertion macros shared by the checksum engine's modules.
`ifndef INTERNET_CHECKSUM_ENGINE_MACROS_SVH
`define INTERNET_CHECKSUM_ENGINE_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define ICE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never hold outside reset.
`define ICE_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- src/icse_pkg.sv -----
// Types, constants and helper functions of the Internet checksum engine.
package icse_pkg;

   // Checksum mode of a packet.
   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_IPV4  = 2'd1,
      MODE_TCP   = 2'd2,
      MODE_UDP   = 2'd3
   } mode_type;

   localparam logic [15:0] PROTO_TCP     = 16'h0006;
   localparam logic [15:0] PROTO_UDP     = 16'h0011;
   localparam logic [15:0] IPV4_CSUM_POS = 16'd10;
   localparam logic [15:0] ALL_ONES      = 16'hFFFF;

   // Default depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;

   // Width of the wide term sum: up to seven 16-bit words.
   localparam int TERM_W = 19;

   // One packet byte as it arrives.
   typedef struct packed {
      mode_type    mode;
      logic [7:0]  data_byte;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic        last;
   } req_type;

   // One finished packet result.
   typedef struct packed {
      logic [15:0] checksum;
      logic [15:0] byte_count;
   } rsp_type;

   // Work handed from the front part to the back part, one per byte.
   typedef struct packed {
      logic        first;
      logic        last;
      logic        udp;
      logic [15:0] term;
      logic [15:0] byte_count;
   } work_type;

   // Ones-complement add of two 16-bit words with end-around carry.
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // Fold a wide sum back to 16 bits with end-around carries.
   function automatic logic [15:0] oc_fold(input logic [TERM_W-1:0] x);
      logic [16:0] f;
      f = {1'b0, x[15:0]} + {14'd0, x[TERM_W-1:16]};
      return f[15:0] + {15'd0, f[16]};
   endfunction

endpackage

// ----- src/icse_queue.sv -----
// Short first-in first-out queue of work entries between front and back.
`include "internet_checksum_engine_macros.svh"

module icse_queue #(
   parameter int Depth = icse_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  icse_pkg::work_type wr_data,
   output logic               full,
   input  logic               pop,
   output icse_pkg::work_type rd_data,
   output logic               empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   icse_pkg::work_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entries_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `ICE_NEVER(a_count_bound, clock, reset, count_ff > CntW'(Depth), "queue count exceeds depth")
   `ICE_ASSERT(a_push_grows, clock, reset, (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CntW'(1)), "push without pop did not grow the queue")
   `ICE_ASSERT(a_pop_shrinks, clock, reset, (do_pop && !do_push) |=> (count_ff == $past(count_ff) - CntW'(1)), "pop without push did not shrink the queue")

endmodule

// ----- src/icse_front.sv -----
// Front part: accepts bytes, pairs them into words and forms one sum term per byte.
module icse_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  icse_pkg::req_type  req_data,
   input  logic               q_full,
   output logic               q_push,
   output icse_pkg::work_type q_data
);

   logic        mid_ff, mid_in;
   logic        odd_ff, odd_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] count_ff, count_in;

   logic                        first;
   logic                        odd;
   logic                        pseudo;
   logic                        blank;
   logic [15:0]                 pos;
   logic [15:0]                 new_count;
   logic [7:0]                  b;
   logic [15:0]                 word;
   logic [15:0]                 proto;
   logic [icse_pkg::TERM_W-1:0] addr_term;
   logic [icse_pkg::TERM_W-1:0] len_term;
   logic [icse_pkg::TERM_W-1:0] term_wide;

   assign q_push = req_push && !q_full;

   // Position of this byte within its packet, and the IPv4 checksum field blanking.
   always_comb begin
      first     = !mid_ff;
      pos       = first ? 16'd0 : count_ff;
      odd       = first ? 1'b0 : odd_ff;
      new_count = pos + 16'd1;
      pseudo    = (req_data.mode == icse_pkg::MODE_TCP) || (req_data.mode == icse_pkg::MODE_UDP);
      blank     = (req_data.mode == icse_pkg::MODE_IPV4) &&
                  ((pos == icse_pkg::IPV4_CSUM_POS) ||
                   (pos == icse_pkg::IPV4_CSUM_POS + 16'd1));
      b         = blank ? 8'd0 : req_data.data_byte;
   end

   // Word completed by this byte, or the zero-padded final odd byte.
   always_comb begin
      if (odd) begin
         word = {held_ff, b};
      end else if (req_data.last) begin
         word = {b, 8'd0};
      end else begin
         word = 16'd0;
      end
   end

   // Pseudo-header terms: addresses and protocol on the first byte, length on the last.
   always_comb begin
      proto     = (req_data.mode == icse_pkg::MODE_TCP) ? icse_pkg::PROTO_TCP
                                                        : icse_pkg::PROTO_UDP;
      addr_term = '0;
      len_term  = '0;
      if (first && pseudo) begin
         addr_term = icse_pkg::TERM_W'(req_data.src_addr[31:16]) +
                     icse_pkg::TERM_W'(req_data.src_addr[15:0]) +
                     icse_pkg::TERM_W'(req_data.dst_addr[31:16]) +
                     icse_pkg::TERM_W'(req_data.dst_addr[15:0]) +
                     icse_pkg::TERM_W'(proto);
      end
      if (req_data.last && pseudo) begin
         len_term = icse_pkg::TERM_W'(new_count);
      end
      term_wide = icse_pkg::TERM_W'(word) + addr_term + len_term;
   end

   // Work entry for the back part.
   always_comb begin
      q_data.first      = first;
      q_data.last       = req_data.last;
      q_data.udp        = (req_data.mode == icse_pkg::MODE_UDP);
      q_data.term       = icse_pkg::oc_fold(term_wide);
      q_data.byte_count = new_count;
   end

   // Packet tracking state.
   always_comb begin
      mid_in   = mid_ff;
      odd_in   = odd_ff;
      held_in  = held_ff;
      count_in = count_ff;
      if (q_push) begin
         if (req_data.last) begin
            mid_in   = 1'b0;
            odd_in   = 1'b0;
            count_in = 16'd0;
         end else begin
            mid_in   = 1'b1;
            odd_in   = !odd;
            held_in  = b;
            count_in = new_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff   <= 1'b0;
         odd_ff   <= 1'b0;
         count_ff <= 16'd0;
      end else begin
         mid_ff   <= mid_in;
         odd_ff   <= odd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

// ----- src/icse_back.sv -----
// Back part: accumulates the ones-complement sum and holds the finished result.
`include "internet_checksum_engine_macros.svh"

module icse_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  icse_pkg::work_type q_data,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output icse_pkg::rsp_type  rsp_data
);

   logic [15:0]       acc_ff, acc_in;
   logic              out_valid_ff, out_valid_in;
   icse_pkg::rsp_type out_ff, out_in;

   logic        slot_free;
   logic        go;
   logic [15:0] sum;
   logic [15:0] ck;

   // A final entry waits until the result register can take it.
   assign slot_free = !out_valid_ff || rsp_pop;
   assign go        = !q_empty && (!q_data.last || slot_free);
   assign q_pop     = go;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // Sum update and final complement.
   always_comb begin
      sum = icse_pkg::oc_add(q_data.first ? 16'd0 : acc_ff, q_data.term);
      ck  = ~sum;
      if (q_data.udp && (ck == 16'd0)) begin
         ck = icse_pkg::ALL_ONES;
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (go) begin
         acc_in = sum;
         if (q_data.last) begin
            out_in.checksum   = ck;
            out_in.byte_count = q_data.byte_count;
            out_valid_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 16'd0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   `ICE_ASSERT(a_result_from_last, clock, reset, (out_valid_ff && !$past(out_valid_ff)) |-> $past(go && q_data.last), "result appeared without a final entry")
   `ICE_NEVER(a_no_overwrite, clock, reset, go && q_data.last && out_valid_ff && !rsp_pop, "waiting result overwritten")

endmodule

// ----- src/internet_checksum_engine.sv -----
// A result is shown once its packet's last byte has passed through the queue into the result register.
// One byte per cycle while the queue is not full, set by the single end-around add in the back part.
// While a result waits, the final entry behind it holds the queue; bytes enter until it fills.
// Reset is synchronous and active high; it clears packet tracking, queue and result.
// After reset the engine waits for the first byte of a packet.
module internet_checksum_engine #(
   parameter int QueueDepth = icse_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  icse_pkg::req_type req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output icse_pkg::rsp_type rsp_data
);

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   icse_pkg::work_type q_wr_data;
   icse_pkg::work_type q_rd_data;

   assign req_full = q_full;

   // Byte intake and term forming.
   icse_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   // Queue between the two parts.
   icse_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   // Accumulation and result register.
   icse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
